[hdl/mf3_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared types and constants of the 3x3 RGB median filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

   localparam int CH_W       = 8;
   localparam int NUM_CH     = 3;
   localparam int PIX_W      = CH_W * NUM_CH;
   localparam int WIN        = 3;
   localparam int ROW_W      = 12;
   localparam int IN_ROW_W   = ROW_W + 1;
   localparam int OCOL_W     = 9;
   localparam int FW_W       = 10;
   localparam int FH_W       = 12;
   localparam int REQ_DATA_W = 24;
   localparam int REQ_USER_W = 1;
   localparam int RSP_DATA_W = 48;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   localparam int FRAME_WIDTH_RST  = 320;
   localparam int FRAME_HEIGHT_RST = 240;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FRAME_WIDTH  = 4'd0,
      REG_FRAME_HEIGHT = 4'd1
   } csr_reg_type;

   // channel 0 in the low byte
   typedef logic [NUM_CH-1:0][CH_W-1:0] pix_type;

   typedef struct packed {
      pix_type up;
      pix_type mid;
      pix_type dn;
   } column_type;

   typedef struct packed {
      logic              emit;
      logic              interior;
      logic              done;
      logic [ROW_W-1:0]  row;
      logic [OCOL_W-1:0] col;
   } ctl_type;

   typedef struct packed {
      logic              done;
      logic [ROW_W-1:0]  row;
      logic [OCOL_W-1:0] col;
      pix_type           pix;
   } result_type;

endpackage
`default_nettype wire

[hdl/mf3_line_store.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mf3_line_store
// Two-line store in one memory: each entry holds the upper and middle pixel
// of a column. Read on accept, rotate and write back from the registered read.
// ----------------------------------------------------------------------------
module mf3_line_store
   import mf3_pkg::*;
#(
   parameter int MAX_WIDTH = 512
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         en,
   input  wire logic                         in_valid,
   input  wire logic [$clog2(MAX_WIDTH)-1:0] in_col,
   input  wire pix_type                      in_pix,
   input  wire ctl_type                      in_ctl,
   output logic                              a_valid,
   output column_type                        a_column,
   output ctl_type                           a_ctl
);

   localparam int COL_W = $clog2(MAX_WIDTH);

   typedef struct packed {
      pix_type up;
      pix_type mid;
   } line_ent_type;

   line_ent_type            line_mem [MAX_WIDTH];
   line_ent_type            rd_ent_ff;
   line_ent_type            fwd_ent_ff;
   line_ent_type            col_ent;
   line_ent_type            wr_ent;
   logic                    fwd_ff;
   logic                    fwd_in;
   logic                    a_valid_ff;
   logic [COL_W-1:0]        a_col_ff;
   pix_type                 a_pix_ff;
   ctl_type                 a_ctl_ff;
   logic                    rd_en;
   logic                    wr_en;

   assign rd_en = en && in_valid;
   assign wr_en = en && a_valid_ff;

   // same column written back while read again (width of one)
   assign col_ent = fwd_ff ? fwd_ent_ff : rd_ent_ff;
   assign wr_ent  = '{up: col_ent.mid, mid: a_pix_ff};
   assign fwd_in  = wr_en && (a_col_ff == in_col);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[a_col_ff] <= wr_ent;
      end
      if (rd_en) begin
         rd_ent_ff <= line_mem[in_col];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         fwd_ff     <= fwd_in;
         fwd_ent_ff <= wr_ent;
         a_col_ff   <= in_col;
         a_pix_ff   <= in_pix;
         a_ctl_ff   <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
      end
   end

   assign a_valid  = a_valid_ff;
   assign a_column = '{up: col_ent.up, mid: col_ent.mid, dn: a_pix_ff};
   assign a_ctl    = a_ctl_ff;

endmodule
`default_nettype wire

[hdl/mf3_window_median.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mf3_window_median
// 3x3 window of presorted columns and a two-stage median-of-nine reduction
// per channel; border pixels take the raw window center.
// ----------------------------------------------------------------------------
module mf3_window_median
   import mf3_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       en,
   input  wire logic       a_valid,
   input  wire column_type a_column,
   input  wire ctl_type    a_ctl,
   output logic            c_valid,
   output result_type      c_result
);

   typedef struct packed {
      logic [CH_W-1:0] hi;
      logic [CH_W-1:0] md;
      logic [CH_W-1:0] lo;
   } sort_type;

   typedef sort_type [NUM_CH-1:0] csort_type;

   function automatic logic [CH_W-1:0] min2(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic [CH_W-1:0] max2(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b);
      return (a < b) ? b : a;
   endfunction

   function automatic logic [CH_W-1:0] med3(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b,
                                            input logic [CH_W-1:0] c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

   function automatic sort_type sort3(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b,
                                      input logic [CH_W-1:0] c);
      logic [CH_W-1:0] l1;
      logic [CH_W-1:0] h1;
      logic [CH_W-1:0] t;
      sort_type        s;
      l1   = min2(a, b);
      h1   = max2(a, b);
      s.hi = max2(h1, c);
      t    = min2(h1, c);
      s.lo = min2(l1, t);
      s.md = max2(l1, t);
      return s;
   endfunction

   csort_type srt_ff [WIN];
   csort_type col_srt;
   pix_type   rawmid_ff;
   pix_type   center_ff;
   ctl_type   b_ctl_ff;
   logic      b_valid_ff;
   pix_type   lomax;
   pix_type   mdmed;
   pix_type   himin;
   pix_type   lomax_ff;
   pix_type   mdmed_ff;
   pix_type   himin_ff;
   pix_type   c_center_ff;
   ctl_type   c_ctl_ff;
   logic      c_valid_ff;
   pix_type   med;

   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         col_srt[ch] = sort3(a_column.up[ch], a_column.mid[ch], a_column.dn[ch]);
         lomax[ch]   = max2(max2(srt_ff[0][ch].lo, srt_ff[1][ch].lo), srt_ff[2][ch].lo);
         mdmed[ch]   = med3(srt_ff[0][ch].md, srt_ff[1][ch].md, srt_ff[2][ch].md);
         himin[ch]   = min2(min2(srt_ff[0][ch].hi, srt_ff[1][ch].hi), srt_ff[2][ch].hi);
         med[ch]     = med3(lomax_ff[ch], mdmed_ff[ch], himin_ff[ch]);
      end
   end

   always_ff @(posedge clock) begin
      if (en && a_valid) begin
         srt_ff[0] <= srt_ff[1];
         srt_ff[1] <= srt_ff[2];
         srt_ff[2] <= col_srt;
         rawmid_ff <= a_column.mid;
         center_ff <= rawmid_ff;
         b_ctl_ff  <= a_ctl;
      end
      if (en) begin
         lomax_ff    <= lomax;
         mdmed_ff    <= mdmed;
         himin_ff    <= himin;
         c_center_ff <= center_ff;
         c_ctl_ff    <= b_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid && a_ctl.emit;
         c_valid_ff <= b_valid_ff;
      end
   end

   assign c_valid       = c_valid_ff;
   assign c_result.done = c_ctl_ff.done;
   assign c_result.row  = c_ctl_ff.row;
   assign c_result.col  = c_ctl_ff.col;
   assign c_result.pix  = c_ctl_ff.interior ? med : c_center_ff;

endmodule
`default_nettype wire

[hdl/mf3_out_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mf3_out_queue
// Two-entry result queue between the filter pipeline and the result channel.
// ----------------------------------------------------------------------------
module mf3_out_queue
   import mf3_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire result_type push_data,
   input  wire logic       pop,
   output logic            out_valid,
   output result_type      out_data,
   output logic            full
);

   result_type slot0_ff;
   result_type slot0_in;
   result_type slot1_ff;
   result_type slot1_in;
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   logic       pop_ok;

   assign pop_ok = pop && (cnt_ff != 2'd0);

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      cnt_in   = cnt_ff;
      unique case ({push, pop_ok})
         2'b00: ;
         2'b01: begin
            slot0_in = slot1_ff;
            cnt_in   = cnt_ff - 2'd1;
         end
         2'b10: begin
            if (cnt_ff == 2'd0) begin
               slot0_in = push_data;
            end else begin
               slot1_in = push_data;
            end
            cnt_in = cnt_ff + 2'd1;
         end
         2'b11: begin
            if (cnt_ff == 2'd1) begin
               slot0_in = push_data;
            end else begin
               slot0_in = slot1_ff;
               slot1_in = push_data;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = slot0_ff;
   assign full      = (cnt_ff == 2'd2);

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("result queue count out of range");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> cnt_ff != 2'd2)
      else $error("result pushed into full queue");

endmodule
`default_nettype wire

[hdl/median_filter_3x3_rgb.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// median_filter_3x3_rgb
// Streaming 3x3 median filter on RGB pixels in raster order; border pixels
// pass through, results lag the input by one line plus one pixel.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  req_     in   req_tvalid/tready    tdata c0,c1,c2; tuser req_type
//  rsp_     out  rsp_tvalid/tready    tdata c0,c1,c2,row,col; tlast frame_done
//  csr_     in   csr_valid/ready      csr_index, csr_data
//
//  One item per cycle unless the result side stalls; the line store memory is
//  read at accept and written back from its registers, same-column overlap is
//  forwarded. A result passes the line store, window and median registers and
//  the result queue. Reset clears positions; the line store needs no clearing
//  pass. A result stall holds the whole pipeline once the two-entry result
//  queue is full; until then items keep being taken.
// ----------------------------------------------------------------------------
module median_filter_3x3_rgb
   import mf3_pkg::*;
#(
   parameter int MAX_WIDTH = 512
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // c0, c1, c2
   input  wire logic [REQ_USER_W-1:0] req_tuser,  // req_type
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,  // c0, c1, c2, row, col, zero pad
   output logic                       rsp_tlast,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int PAD_W = RSP_DATA_W - (OCOL_W + ROW_W + PIX_W);
   localparam logic [COL_W-1:0] LAST_COL_RST =
      COL_W'((FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH - 1 : FRAME_WIDTH_RST - 1);
   localparam logic [ROW_W-1:0] LAST_ROW_RST = ROW_W'(FRAME_HEIGHT_RST - 1);

   logic [COL_W-1:0]    last_col_ff;
   logic [COL_W-1:0]    last_col_in;
   logic [ROW_W-1:0]    last_row_ff;
   logic [ROW_W-1:0]    last_row_in;
   logic [COL_W-1:0]    in_col_ff;
   logic [COL_W-1:0]    in_col_in;
   logic [IN_ROW_W-1:0] in_row_ff;
   logic [IN_ROW_W-1:0] in_row_in;
   logic [COL_W-1:0]    out_col_ff;
   logic [COL_W-1:0]    out_col_in;
   logic [ROW_W-1:0]    out_row_ff;
   logic [ROW_W-1:0]    out_row_in;

   logic                en;
   logic                accept;
   logic                active;
   logic                step;
   logic                csr_we;
   logic                wr_width;
   logic                wr_height;
   logic [FW_W-1:0]     fw;
   logic [FW_W-1:0]     fw_m1;
   logic [FH_W-1:0]     fh;
   logic [ROW_W-1:0]    fh_m1;
   ctl_type             ctl;
   logic                a_valid;
   column_type          a_column;
   ctl_type             a_ctl;
   logic                c_valid;
   result_type          c_result;
   result_type          q_data;
   logic                q_full;

   assign en         = !q_full || rsp_tready;
   assign req_tready = en;
   assign csr_ready  = 1'b1;

   assign accept = req_tvalid && req_tready;
   assign active = in_row_ff <= {1'b0, last_row_ff};
   // flush inside the frame is dropped
   assign step   = accept && !(req_tuser[0] && active);

   assign csr_we    = csr_valid && csr_ready;
   assign wr_width  = csr_we && (csr_index == REG_FRAME_WIDTH);
   assign wr_height = csr_we && (csr_index == REG_FRAME_HEIGHT);
   assign fw        = csr_data[FW_W-1:0];
   assign fh        = csr_data[FH_W-1:0];
   assign fw_m1     = (fw == '0) ? '0 : fw - FW_W'(1);
   assign fh_m1     = (fh == '0) ? '0 : ROW_W'(fh - FH_W'(1));

   always_comb begin
      ctl.emit     = !((in_row_ff == '0) || ((in_row_ff == IN_ROW_W'(1)) && (in_col_ff == '0)));
      ctl.interior = (out_row_ff != '0) && (out_row_ff < last_row_ff)
                  && (out_col_ff != '0) && (out_col_ff < last_col_ff);
      ctl.done     = ctl.emit && (out_row_ff == last_row_ff) && (out_col_ff == last_col_ff);
      ctl.row      = out_row_ff;
      ctl.col      = OCOL_W'(out_col_ff);
   end

   always_comb begin
      last_col_in = last_col_ff;
      last_row_in = last_row_ff;
      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      if (wr_width) begin
         if (32'(fw_m1) > 32'(MAX_WIDTH - 1)) begin
            last_col_in = COL_W'(MAX_WIDTH - 1);
         end else begin
            last_col_in = COL_W'(fw_m1);
         end
      end
      if (wr_height) begin
         last_row_in = fh_m1;
      end
      priority if (wr_width || wr_height) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (step) begin
         if (in_col_ff == last_col_ff) begin
            in_col_in = '0;
            in_row_in = in_row_ff + IN_ROW_W'(1);
         end else begin
            in_col_in = in_col_ff + COL_W'(1);
         end
         if (ctl.done) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
         end else if (ctl.emit) begin
            if (out_col_ff == last_col_ff) begin
               out_col_in = '0;
               out_row_in = out_row_ff + ROW_W'(1);
            end else begin
               out_col_in = out_col_ff + COL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_col_ff <= LAST_COL_RST;
         last_row_ff <= LAST_ROW_RST;
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
      end else begin
         last_col_ff <= last_col_in;
         last_row_ff <= last_row_in;
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
      end
   end

   mf3_line_store #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_store (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (step),
      .in_col   (in_col_ff),
      .in_pix   (pix_type'(req_tdata)),
      .in_ctl   (ctl),
      .a_valid  (a_valid),
      .a_column (a_column),
      .a_ctl    (a_ctl)
   );

   mf3_window_median u_window_median (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .a_valid  (a_valid),
      .a_column (a_column),
      .a_ctl    (a_ctl),
      .c_valid  (c_valid),
      .c_result (c_result)
   );

   mf3_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (en && c_valid),
      .push_data (c_result),
      .pop       (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_data  (q_data),
      .full      (q_full)
   );

   assign rsp_tdata = {PAD_W'(0), q_data.col, q_data.row, q_data.pix};
   assign rsp_tlast = q_data.done;

   a_in_col_range: assert property (@(posedge clock) disable iff (reset)
      in_col_ff <= last_col_ff)
      else $error("input column beyond line width");

   a_out_col_range: assert property (@(posedge clock) disable iff (reset)
      out_col_ff <= last_col_ff)
      else $error("result column beyond line width");

   a_out_row_range: assert property (@(posedge clock) disable iff (reset)
      out_row_ff <= last_row_ff)
      else $error("result row beyond frame height");

endmodule
`default_nettype wire

[sim/tb_median_filter_3x3_rgb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_median_filter_3x3_rgb
// Self-checking bench for the 3x3 RGB median filter. A behavioral copy of the
// filter (line ring, border pass-through, per-channel median of nine) predicts
// each filtered pixel as input items are taken; the result stream is compared
// field by field in order. Covers clamped and degenerate frame sizes, flushes
// inside and after frames, register restarts, a long result stall and random
// frames with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_median_filter_3x3_rgb;
   import mf3_pkg::*;

   localparam int          MAX_W         = 512;
   localparam int          HALF          = WIN / 2;
   localparam int          SETTLE_CYCLES = 12;
   localparam int          LONG_HOLD     = 400;
   localparam int          RANDOM_PIXELS = 800;
   localparam int          CSR_IDX_TOP   = (1 << CSR_IDX_W) - 1;
   localparam int          ROW_LSB       = PIX_W;
   localparam int          COL_LSB       = ROW_LSB + ROW_W;
   localparam int          PAD_LSB       = COL_LSB + OCOL_W;
   localparam longint      TIMEOUT_NS    = 64'd60_000_000;

   typedef enum logic {
      ITEM_PIXEL = 1'b0,
      ITEM_FLUSH = 1'b1
   } item_kind_t;

   typedef struct {
      pix_type           pix;
      logic [ROW_W-1:0]  row;
      logic [OCOL_W-1:0] col;
      logic              done;
   } filtered_pixel_t;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // c0, c1, c2
   logic [REQ_USER_W-1:0] req_tuser;   // req_type
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // c0, c1, c2, row, col, zero pad
   logic                  rsp_tlast;   // frame_done
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // filter state mirrored by the bench
   pix_type               line_mem [WIN][MAX_W];
   int unsigned           width_reg  = FRAME_WIDTH_RST;
   int unsigned           height_reg = FRAME_HEIGHT_RST;
   int unsigned           pos_row    = 0;
   int unsigned           pos_col    = 0;
   int unsigned           emit_idx   = 0;

   filtered_pixel_t       expected_pixels [$];
   int unsigned           error_count    = 0;
   int unsigned           pixels_sent    = 0;
   bit                    src_gaps       = 1'b0;
   bit                    sink_gaps      = 1'b0;
   int unsigned           noise_pct      = 0;
   int unsigned           tail_pixel_pct = 0;
   int unsigned           hold_off       = 0;

   median_filter_3x3_rgb dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------------
   function automatic int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_W) return MAX_W;
      return width_reg;
   endfunction

   function automatic int unsigned eff_height();
      if (height_reg == 0) return 1;
      return height_reg;
   endfunction

   function automatic void restart_frame();
      pos_row  = 0;
      pos_col  = 0;
      emit_idx = 0;
   endfunction

   function automatic logic [CH_W-1:0] median_of_window(input pix_type win_px [WIN*WIN],
                                                        input int ch);
      logic [CH_W-1:0] v [WIN*WIN];
      logic [CH_W-1:0] t;
      int              i, j;
      for (i = 0; i < WIN*WIN; i++) v[i] = win_px[i][ch];
      for (i = 1; i < WIN*WIN; i++) begin
         t = v[i];
         j = i - 1;
         while (j >= 0 && v[j] > t) begin
            v[j+1] = v[j];
            j--;
         end
         v[j+1] = t;
      end
      return v[(WIN*WIN)/2];
   endfunction

   task automatic predict_item(input item_kind_t kind, input pix_type px);
      int unsigned     w, h, k, ro, co, i, j;
      pix_type         win_px [WIN*WIN];
      filtered_pixel_t res;
      w = eff_width();
      h = eff_height();
      if (kind == ITEM_FLUSH && pos_row < h) return;
      if (pos_row < h) line_mem[pos_row % WIN][pos_col] = px;
      k = pos_row * w + pos_col;
      pos_col++;
      if (pos_col >= w) begin
         pos_col = 0;
         pos_row++;
      end
      if (k < HALF * w + HALF) return;
      ro = emit_idx / w;
      co = emit_idx % w;
      if (ro < HALF || ro + HALF >= h || co < HALF || co + HALF >= w) begin
         res.pix = line_mem[ro % WIN][co];
      end else begin
         for (i = 0; i < WIN; i++)
            for (j = 0; j < WIN; j++)
               win_px[i*WIN + j] = line_mem[(ro - HALF + i) % WIN][co - HALF + j];
         for (i = 0; i < NUM_CH; i++) res.pix[i] = median_of_window(win_px, i);
      end
      res.row  = ROW_W'(ro);
      res.col  = OCOL_W'(co);
      res.done = (emit_idx == w * h - 1);
      expected_pixels.push_back(res);
      if (res.done) restart_frame();
      else emit_idx++;
   endtask

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   function automatic int unsigned pick_gap();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
   endfunction

   function automatic pix_type rand_pixel();
      pix_type px;
      int      ch;
      for (ch = 0; ch < NUM_CH; ch++)
         case ($urandom_range(0, 5))
            0:       px[ch] = 8'h00;
            1:       px[ch] = 8'hFF;
            2:       px[ch] = 8'($urandom_range(0, 3));
            default: px[ch] = 8'($urandom);
         endcase
      return px;
   endfunction

   // called at a falling edge, returns at the falling edge after the item is taken
   task automatic send_item(input item_kind_t kind, input pix_type px);
      if (src_gaps && $urandom_range(0, 99) < 20) begin
         req_tvalid <= 1'b0;
         repeat (pick_gap()) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= px;
      do @(posedge clock); while (req_tready !== 1'b1);
      predict_item(kind, px);
      if (kind == ITEM_PIXEL) pixels_sent++;
      @(negedge clock);
   endtask

   // n_pix items of the frame; with close set, keeps going until frame end
   task automatic stream_frame(input int unsigned n_pix, input bit close);
      int unsigned n;
      n = 0;
      while (n < n_pix || (close && (pos_row != 0 || pos_col != 0))) begin
         if (pos_row < eff_height()) begin
            if ($urandom_range(0, 99) < noise_pct) send_item(ITEM_FLUSH, rand_pixel());
            send_item(ITEM_PIXEL, rand_pixel());
         end else begin
            send_item($urandom_range(0, 99) < tail_pixel_pct ? ITEM_PIXEL : ITEM_FLUSH,
                      rand_pixel());
         end
         n++;
      end
   endtask

   // input idle, all results in, pipeline drained
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_pixels.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      settle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         REG_FRAME_WIDTH: begin
            width_reg = value[FW_W-1:0];
            restart_frame();
         end
         REG_FRAME_HEIGHT: begin
            height_reg = value[FH_W-1:0];
            restart_frame();
         end
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // result side
   // ------------------------------------------------------------------------
   initial begin : rsp_ready_gen
      int unsigned stall;
      stall      = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off != 0) begin
            rsp_tready <= 1'b0;
            hold_off--;
         end else if (stall != 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
            if (sink_gaps && $urandom_range(0, 99) < 20) stall = pick_gap();
         end
      end
   end

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   initial begin : result_checker
      filtered_pixel_t want;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
            if (expected_pixels.size() == 0) begin
               $error("unexpected item: row %0d col %0d",
                      rsp_tdata[COL_LSB-1:ROW_LSB], rsp_tdata[PAD_LSB-1:COL_LSB]);
               error_count++;
            end else begin
               want = expected_pixels.pop_front();
               check_field("out_c0", want.pix[0], rsp_tdata[CH_W-1:0]);
               check_field("out_c1", want.pix[1], rsp_tdata[2*CH_W-1:CH_W]);
               check_field("out_c2", want.pix[2], rsp_tdata[PIX_W-1:2*CH_W]);
               check_field("out_row", want.row, rsp_tdata[COL_LSB-1:ROW_LSB]);
               check_field("out_col", want.col, rsp_tdata[PAD_LSB-1:COL_LSB]);
               check_field("frame_done", want.done, rsp_tlast);
               check_field("pad", 0, rsp_tdata[RSP_DATA_W-1:PAD_LSB]);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   // register defaults: 320 wide, so results start after one line plus one pixel
   task automatic test_reset_defaults();
      src_gaps  = 1'b1;
      sink_gaps = 1'b1;
      stream_frame(330, 1'b0);
   endtask

   // smallest frame with an interior pixel; flush inside the frame and a
   // pixel after the last one are both ignored as data
   task automatic test_small_frame();
      pix_type grid [9];
      int      i;
      grid = '{24'h000000, 24'hFFFFFF, 24'h80017F, 24'h7F8001, 24'h01FF80,
               24'hFE0102, 24'h55AA33, 24'hAA5533, 24'h3355AA};
      write_csr(REG_FRAME_WIDTH, 16'd3);
      write_csr(REG_FRAME_HEIGHT, 16'd3);
      tail_pixel_pct = 0;
      noise_pct      = 0;
      for (i = 0; i < 9; i++) begin
         if (i == 4) send_item(ITEM_FLUSH, 24'hFFFFFF);
         send_item(ITEM_PIXEL, grid[i]);
      end
      send_item(ITEM_PIXEL, 24'hABCDEF);
      stream_frame(0, 1'b1);
   endtask

   // zero sizes count as one; frames smaller than the window are all border
   task automatic test_degenerate_sizes();
      noise_pct      = 10;
      tail_pixel_pct = 30;
      write_csr(REG_FRAME_WIDTH, 16'hFC00);
      write_csr(REG_FRAME_HEIGHT, 16'd4);
      stream_frame(4, 1'b1);
      write_csr(REG_FRAME_WIDTH, 16'd2);
      write_csr(REG_FRAME_HEIGHT, 16'hF000);
      stream_frame(2, 1'b1);
      write_csr(REG_FRAME_HEIGHT, 16'd2);
      stream_frame(4, 1'b1);
      write_csr(REG_FRAME_WIDTH, 16'd7);
      stream_frame(14, 1'b1);
      write_csr(REG_FRAME_WIDTH, 16'd2);
      write_csr(REG_FRAME_HEIGHT, 16'd6);
      stream_frame(12, 1'b1);
      stream_frame(12, 1'b1);
   endtask

   // unknown index leaves the frame running, a real write restarts it
   task automatic test_register_restart();
      write_csr(REG_FRAME_WIDTH, 16'd4);
      write_csr(REG_FRAME_HEIGHT, 16'd5);
      stream_frame(9, 1'b0);
      write_csr(CSR_IDX_TOP, 16'hFFFF);
      write_csr(CSR_IDX_W'($urandom_range(int'(REG_FRAME_HEIGHT) + 1, CSR_IDX_TOP)),
                16'($urandom));
      stream_frame(0, 1'b1);
      stream_frame(7, 1'b0);
      write_csr(REG_FRAME_WIDTH, 16'd4);
      stream_frame(20, 1'b1);
   endtask

   // width clamp to the full line store, then the tallest frame (partial)
   task automatic test_extreme_sizes();
      write_csr(REG_FRAME_WIDTH, 16'h03FF);
      write_csr(REG_FRAME_HEIGHT, 16'd3);
      stream_frame(MAX_W * 3, 1'b1);
      write_csr(REG_FRAME_WIDTH, 16'd512);
      write_csr(REG_FRAME_HEIGHT, 16'hFFFF);
      stream_frame(2 * MAX_W + 40, 1'b0);
   endtask

   // long result stall while items keep coming: pipeline fills, input stalls
   task automatic test_backpressure();
      write_csr(REG_FRAME_WIDTH, 16'd16);
      write_csr(REG_FRAME_HEIGHT, 16'd8);
      src_gaps       = 1'b0;
      sink_gaps      = 1'b0;
      noise_pct      = 0;
      tail_pixel_pct = 0;
      hold_off       = LONG_HOLD;
      stream_frame(16 * 8, 1'b1);
   endtask

   task automatic test_random_frames();
      int unsigned first_pixel, w, h, total;
      bit          need_cfg;
      first_pixel = pixels_sent;
      need_cfg    = 1'b1;
      while (pixels_sent - first_pixel < RANDOM_PIXELS) begin
         src_gaps       = ($urandom_range(0, 3) != 0);
         sink_gaps      = ($urandom_range(0, 3) != 0);
         noise_pct      = $urandom_range(0, 15);
         tail_pixel_pct = $urandom_range(0, 40);
         if ($urandom_range(0, 9) == 0)
            write_csr(CSR_IDX_W'($urandom_range(int'(REG_FRAME_HEIGHT) + 1, CSR_IDX_TOP)),
                      16'($urandom));
         if (need_cfg || $urandom_range(0, 99) < 60) begin
            case ($urandom_range(0, 9))
               0:       w = $urandom_range(1, 2);
               1:       w = $urandom_range(11, 24);
               default: w = $urandom_range(3, 10);
            endcase
            case ($urandom_range(0, 9))
               0:       h = $urandom_range(1, 2);
               1:       h = $urandom_range(9, 12);
               default: h = $urandom_range(3, 8);
            endcase
            write_csr(REG_FRAME_WIDTH,
                      {($urandom_range(0, 2) == 0) ? 6'($urandom) : 6'd0, 10'(w)});
            write_csr(REG_FRAME_HEIGHT,
                      {($urandom_range(0, 2) == 0) ? 4'($urandom) : 4'd0, 12'(h)});
            need_cfg = 1'b0;
         end
         total = eff_width() * eff_height();
         if (total > 1 && $urandom_range(0, 9) == 0) begin
            stream_frame($urandom_range(1, total - 1), 1'b0);
            need_cfg = 1'b1;
         end else begin
            stream_frame(total, 1'b1);
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin : main_seq
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_small_frame();
      test_degenerate_sizes();
      test_register_restart();
      test_extreme_sizes();
      test_backpressure();
      test_random_frames();
      settle();

      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("tb: failure");
      $finish;
   end

endmodule
